// ===== hw/rtl/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the lru page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;
    localparam int SLOT_W    = 3;
    localparam int RANK_W    = 3;
    localparam int NUM_W     = 4;
    localparam int CNT_W     = 32;

    localparam logic [NUM_W-1:0]  FRAMES_RESET = NUM_W'(FRAMES);
    localparam logic [RANK_W-1:0] RANK_MAX     = RANK_W'(FRAMES - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX      = {CNT_W{1'b1}};

    typedef logic [FRAMES-1:0][PAGE_BITS-1:0] t_page_arr;
    typedef logic [FRAMES-1:0][RANK_W-1:0]    t_rank_arr;
    typedef logic [FRAMES-1:0]                t_frame_mask;

    typedef struct packed {
        logic                 hit;
        logic                 fill;
        logic [SLOT_W-1:0]    slot;
        logic                 ev_valid;
        logic [PAGE_BITS-1:0] ev_page;
        t_frame_mask          age;
    } t_lookup;

endpackage

// ===== hw/rtl/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// Eight-frame lru page replacement unit with hit and fault totals.
// ----------------------------------------------------------------------------
// One page reference is taken per clock: busy never rises, so start may be
// held high every cycle. The item is registered at the edge that accepts it,
// the frame compare, lru pick and rank update run in the following cycle,
// and the result is registered at the next edge: it sits on the output ports
// with o_strobe high for one cycle. The receiver cannot stall; results not
// taken in that cycle are gone. The frames_in_use register is always ready.
// ----------------------------------------------------------------------------
module lru_page_replacement
    import lrupr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [PAGE_BITS-1:0] i_page_number,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [NUM_W-1:0]     i_cfg_data,
    output logic                 o_strobe,
    output logic                 o_hit,
    output logic [SLOT_W-1:0]    o_frame_slot,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [CNT_W-1:0]     o_hit_total,
    output logic [CNT_W-1:0]     o_fault_total
);

    logic                 r_in_valid;
    logic [PAGE_BITS-1:0] r_in_page;
    logic [NUM_W-1:0]     r_frames_in_use;
    logic [CNT_W-1:0]     r_hit_cnt;
    logic [CNT_W-1:0]     r_fault_cnt;
    logic                 r_strobe;
    logic                 r_hit;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_ev_valid;
    logic [PAGE_BITS-1:0] r_ev_page;

    t_page_arr        frame_page;
    t_frame_mask      frame_valid;
    t_rank_arr        rank;
    logic [NUM_W-1:0] fill_count;
    t_lookup          lookup;
    logic             accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_frames_in_use <= FRAMES_RESET;
            r_hit_cnt       <= '0;
            r_fault_cnt     <= '0;
            r_strobe        <= 1'b0;
        end else begin
            r_in_valid <= accept;
            r_strobe   <= r_in_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_frames_in_use <= i_cfg_data;
            end
            if (r_in_valid) begin
                if (lookup.hit && (r_hit_cnt != CNT_MAX)) begin
                    r_hit_cnt <= r_hit_cnt + CNT_W'(1);
                end
                if (!lookup.hit && (r_fault_cnt != CNT_MAX)) begin
                    r_fault_cnt <= r_fault_cnt + CNT_W'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_page <= i_page_number;
        end
        if (r_in_valid) begin
            r_hit      <= lookup.hit;
            r_slot     <= lookup.slot;
            r_ev_valid <= lookup.ev_valid;
            r_ev_page  <= lookup.ev_page;
        end
    end

    lrupr_lookup u_lookup (
        .i_page          (r_in_page),
        .i_frames_in_use (r_frames_in_use),
        .i_fill_count    (fill_count),
        .i_frame_page    (frame_page),
        .i_frame_valid   (frame_valid),
        .i_rank          (rank),
        .o_lookup        (lookup)
    );

    lrupr_frames u_frames (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (r_in_valid),
        .i_page        (r_in_page),
        .i_lookup      (lookup),
        .o_frame_page  (frame_page),
        .o_frame_valid (frame_valid),
        .o_rank        (rank),
        .o_fill_count  (fill_count)
    );

    assign o_strobe        = r_strobe;
    assign o_hit           = r_hit;
    assign o_frame_slot    = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_hit_total     = r_hit_cnt;
    assign o_fault_total   = r_fault_cnt;

endmodule

// ===== hw/rtl/lrupr_lookup.sv =====
// ----------------------------------------------------------------------------
// lrupr_lookup
// Parallel tag compare, lru victim pick and aging decision for one reference.
// ----------------------------------------------------------------------------
module lrupr_lookup
    import lrupr_pkg::*;
(
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [NUM_W-1:0]     i_frames_in_use,
    input  logic [NUM_W-1:0]     i_fill_count,
    input  t_page_arr            i_frame_page,
    input  t_frame_mask          i_frame_valid,
    input  t_rank_arr            i_rank,
    output t_lookup              o_lookup
);

    logic [NUM_W-1:0]  active_count;
    t_frame_mask       active;
    t_frame_mask       match;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] victim;
    logic [RANK_W-1:0] victim_rank;
    logic              fill;
    logic [SLOT_W-1:0] slot;
    logic [NUM_W-1:0]  limit;

    // zero acts as one, oversize clamps to the frame count
    always_comb begin
        if (i_frames_in_use == '0) begin
            active_count = NUM_W'(1);
        end else if (i_frames_in_use > FRAMES_RESET) begin
            active_count = FRAMES_RESET;
        end else begin
            active_count = i_frames_in_use;
        end
    end

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            active[i] = NUM_W'(i) < active_count;
            match[i]  = active[i] && i_frame_valid[i] && (i_frame_page[i] == i_page);
        end
    end

    // lowest matching index wins
    always_comb begin
        hit_slot = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_slot = SLOT_W'(i);
            end
        end
    end

    assign hit = |match;

    // oldest rank, ties go to the lowest index
    always_comb begin
        victim      = '0;
        victim_rank = i_rank[0];
        for (int i = 1; i < FRAMES; i++) begin
            if (active[i] && (i_rank[i] > victim_rank)) begin
                victim      = SLOT_W'(i);
                victim_rank = i_rank[i];
            end
        end
    end

    assign fill  = !hit && (i_fill_count < active_count);
    assign slot  = hit ? hit_slot : (fill ? i_fill_count[SLOT_W-1:0] : victim);
    assign limit = hit ? {1'b0, i_rank[hit_slot]} : FRAMES_RESET;

    always_comb begin
        o_lookup.hit      = hit;
        o_lookup.fill     = fill;
        o_lookup.slot     = slot;
        o_lookup.ev_valid = !hit && !fill && i_frame_valid[slot];
        o_lookup.ev_page  = o_lookup.ev_valid ? i_frame_page[slot] : '0;
        for (int i = 0; i < FRAMES; i++) begin
            o_lookup.age[i] = (SLOT_W'(i) != slot) && active[i] && i_frame_valid[i]
                              && ({1'b0, i_rank[i]} < limit) && (i_rank[i] != RANK_MAX);
        end
    end

endmodule

// ===== hw/rtl/lrupr_frames.sv =====
// ----------------------------------------------------------------------------
// lrupr_frames
// Frame table: resident pages, valid flags, recency ranks and fill pointer.
// ----------------------------------------------------------------------------
module lrupr_frames
    import lrupr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [PAGE_BITS-1:0] i_page,
    input  t_lookup              i_lookup,
    output t_page_arr            o_frame_page,
    output t_frame_mask          o_frame_valid,
    output t_rank_arr            o_rank,
    output logic [NUM_W-1:0]     o_fill_count
);

    t_page_arr        r_page;
    t_frame_mask      r_valid;
    t_rank_arr        r_rank;
    logic [NUM_W-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rank  <= '0;
            r_fill  <= '0;
        end else if (i_en) begin
            for (int i = 0; i < FRAMES; i++) begin
                if (SLOT_W'(i) == i_lookup.slot) begin
                    r_rank[i] <= '0;
                end else if (i_lookup.age[i]) begin
                    r_rank[i] <= r_rank[i] + RANK_W'(1);
                end
            end
            if (!i_lookup.hit) begin
                r_valid[i_lookup.slot] <= 1'b1;
            end
            if (i_lookup.fill) begin
                r_fill <= r_fill + NUM_W'(1);
            end
        end
    end

    // page payload, no reset needed since every read is gated by valid
    always_ff @(posedge i_clk) begin
        if (i_en && !i_lookup.hit) begin
            r_page[i_lookup.slot] <= i_page;
        end
    end

    assign o_frame_page  = r_page;
    assign o_frame_valid = r_valid;
    assign o_rank        = r_rank;
    assign o_fill_count  = r_fill;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for lru_page_replacement. Page references go in
// through the start/busy handshake in random bursts. The frame count register
// is rewritten between phases. A local lru model predicts each result, and
// every strobed result is compared field by field against it.
// ----------------------------------------------------------------------------
module testbench;
    import lrupr_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int POOL_MAX     = 12;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic                 ev_valid;
        logic [PAGE_BITS-1:0] ev_page;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     fault_total;
    } t_page_outcome;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [PAGE_BITS-1:0] i_page_number;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [NUM_W-1:0]     i_cfg_data;
    logic                 o_strobe;
    logic                 o_hit;
    logic [SLOT_W-1:0]    o_frame_slot;
    logic                 o_evicted_valid;
    logic [PAGE_BITS-1:0] o_evicted_page;
    logic [CNT_W-1:0]     o_hit_total;
    logic [CNT_W-1:0]     o_fault_total;

    // lru model state
    logic [NUM_W-1:0]     frames_cfg = FRAMES_RESET;
    logic [PAGE_BITS-1:0] held_page [FRAMES];
    bit                   held_valid [FRAMES];
    int                   age_rank [FRAMES];
    int                   filled = 0;
    logic [CNT_W-1:0]     hits_seen = '0;
    logic [CNT_W-1:0]     faults_seen = '0;

    t_page_outcome        pending_results [$];
    int                   items_accepted = 0;
    int                   cfg_writes = 0;
    int                   mismatches = 0;
    int                   cycle_count = 0;

    logic [PAGE_BITS-1:0] page_pool [POOL_MAX];
    int                   pool_size = 1;

    lru_page_replacement dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page_number   (i_page_number),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_hit           (o_hit),
        .o_frame_slot    (o_frame_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_hit_total     (o_hit_total),
        .o_fault_total   (o_fault_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < FRAMES; i++) begin
            held_page[i]  = '0;
            held_valid[i] = 1'b0;
            age_rank[i]   = 0;
        end
    end

    // applies one reference to the lru model and returns what the block must report
    function automatic t_page_outcome lookup_page(input logic [PAGE_BITS-1:0] page);
        t_page_outcome r;
        int            n;
        int            slot;
        int            limit;
        bit            found;
        r = '{default: '0};
        n = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
        found = 1'b0;
        slot = 0;
        for (int i = 0; i < n; i++) begin
            if (!found && held_valid[i] && held_page[i] == page) begin
                found = 1'b1;
                slot = i;
            end
        end
        if (found) begin
            if (hits_seen != CNT_MAX) hits_seen++;
            limit = age_rank[slot];
        end else begin
            if (faults_seen != CNT_MAX) faults_seen++;
            if (filled < n) begin
                slot = filled;
                filled++;
            end else begin
                // oldest frame wins, lowest index on a tie
                for (int i = 1; i < n; i++)
                    if (age_rank[i] > age_rank[slot]) slot = i;
                r.ev_valid = held_valid[slot];
                r.ev_page  = held_valid[slot] ? held_page[slot] : '0;
            end
            held_page[slot]  = page;
            held_valid[slot] = 1'b1;
            limit = FRAMES;
        end
        for (int i = 0; i < n; i++)
            if (i != slot && held_valid[i] && age_rank[i] < limit && age_rank[i] < FRAMES - 1)
                age_rank[i]++;
        age_rank[slot] = 0;
        r.hit         = found;
        r.slot        = SLOT_W'(slot);
        r.hit_total   = hits_seen;
        r.fault_total = faults_seen;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
                     field, cycle_count, want, got);
            mismatches++;
        end
    endtask

    // samples at the rising edge, before the block's registers move
    always @(posedge i_clk) begin
        t_page_outcome want;
        cycle_count++;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                frames_cfg = i_cfg_data;
                cfg_writes++;
            end
            if (start && !busy) begin
                pending_results.push_back(lookup_page(i_page_number));
                items_accepted++;
            end
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    // a strobe with no item outstanding
                    note_mismatch("strobe", CNT_W'(0), CNT_W'(1));
                end else begin
                    want = pending_results.pop_front();
                    note_mismatch("hit", CNT_W'(want.hit), CNT_W'(o_hit));
                    note_mismatch("frame_slot", CNT_W'(want.slot), CNT_W'(o_frame_slot));
                    note_mismatch("evicted_valid", CNT_W'(want.ev_valid),
                                  CNT_W'(o_evicted_valid));
                    note_mismatch("evicted_page", CNT_W'(want.ev_page),
                                  CNT_W'(o_evicted_page));
                    note_mismatch("hit_total", want.hit_total, o_hit_total);
                    note_mismatch("fault_total", want.fault_total, o_fault_total);
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("lru_page_replacement regression: fail");
        $finish;
    end

    // called at a falling edge; leaves start high on return
    task automatic send_page(input logic [PAGE_BITS-1:0] page);
        int target;
        target = items_accepted + 1;
        start = 1'b1;
        i_page_number = page;
        do @(negedge i_clk); while (items_accepted < target);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            start = 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_frames(input logic [NUM_W-1:0] count);
        int target;
        start = 1'b0;
        wait_drained();
        target = cfg_writes + 1;
        i_cfg_valid = 1'b1;
        i_cfg_data = count;
        do @(negedge i_clk); while (cfg_writes < target);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [PAGE_BITS-1:0] next_page();
        if ($urandom_range(0, 3) != 0)
            return page_pool[$urandom_range(0, pool_size - 1)];
        return PAGE_BITS'($urandom_range(0, 65535));
    endfunction

    // empty frames hold zero but must not hit; fill all eight, then hits and an eviction
    task automatic test_first_fill();
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h1234);
        send_page(16'h8000);
        send_page(16'h0001);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h7FFF);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'hC3C3);
    endtask

    // lowered count hides upper frames, raised count brings them back, 0 and 15 clamp
    task automatic test_frame_counts();
        write_frames(4'd3);
        send_page(16'hAAAA);
        write_frames(4'd8);
        send_page(16'h7FFF);
        write_frames(4'd0);
        send_page(16'h0F0F);
        send_page(16'h0F0F);
        send_page(16'hF0F0);
        write_frames(4'd15);
        send_page(16'h1234);
        send_page(16'h7FFF);
    endtask

    task automatic test_random_traffic();
        int               sent;
        int               phase_sent;
        int               phase_len;
        int               burst;
        bit               steady;
        logic [NUM_W-1:0] count;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       count = 4'd0;
                1:       count = 4'd15;
                2:       count = 4'd1;
                3:       count = 4'd8;
                4:       count = 4'd9;
                default: count = NUM_W'($urandom_range(0, 15));
            endcase
            write_frames(count);
            // a pool of 2 to POOL_MAX pages gives hits, and evictions when it is larger than the frame count
            pool_size = $urandom_range(2, POOL_MAX);
            for (int k = 0; k < pool_size; k++)
                page_pool[k] = PAGE_BITS'($urandom_range(0, 65535));
            steady = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 250);
            phase_sent = 0;
            while (phase_sent < phase_len) begin
                burst = $urandom_range(1, 24);
                repeat (burst) send_page(next_page());
                phase_sent += burst;
                if (!steady) idle_for($urandom_range(0, 6));
            end
            sent += phase_sent;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_page_number = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_first_fill();
        test_frame_counts();
        test_random_traffic();

        start = 1'b0;
        wait_drained();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("lru_page_replacement regression: pass");
        end else begin
            $display("lru_page_replacement regression: fail");
        end
        $finish;
    end

endmodule
